>>> rtl/core/pfd_pkg.sv
// Shared types, constants, arithmetic helpers and microcode for the PID controller.
package pfd_pkg;

    // Number format and datapath sizes.
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int PARAM_W = 31;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int QUO_W   = DATA_W + FRAC_W;
    localparam int CNT_W   = 6;
    localparam int UPC_W   = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_TRACKING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LOW    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_HIGH   = 3'd7;

    // Configuration register bank as seen by the datapath.
    typedef struct packed {
        logic signed [DATA_W-1:0]  gain_p;
        logic signed [DATA_W-1:0]  gain_i;
        logic signed [DATA_W-1:0]  gain_d;
        logic signed [DATA_W-1:0]  gain_tracking;
        logic        [PARAM_W-1:0] filter_time;
        logic        [PARAM_W-1:0] sample_period;
        logic signed [DATA_W-1:0]  output_low;
        logic signed [DATA_W-1:0]  output_high;
    } cfg_t;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_MOV,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_CLAMP,
        OP_DIV,
        OP_CLEAR
    } op_t;

    // Operand sources.
    typedef enum logic [4:0] {
        SRC_ZERO,
        SRC_TARGET,
        SRC_MEAS,
        SRC_PREV,
        SRC_FD,
        SRC_INT,
        SRC_ERR,
        SRC_DM,
        SRC_A,
        SRC_B,
        SRC_C,
        SRC_DRV,
        SRC_CLP,
        SRC_PROD,
        SRC_DIVQ,
        SRC_GP,
        SRC_GI,
        SRC_GD,
        SRC_GT,
        SRC_TF,
        SRC_DT
    } src_t;

    // Result destinations.
    typedef enum logic [3:0] {
        DST_NONE,
        DST_ERR,
        DST_DM,
        DST_A,
        DST_B,
        DST_C,
        DST_DRV,
        DST_CLP,
        DST_FD,
        DST_INT,
        DST_PREV
    } dst_t;

    // Jump conditions.
    typedef enum logic [1:0] {
        COND_NONE,
        COND_MODE,
        COND_DIV_BUSY
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        op_t              op;
        src_t             src_a;
        src_t             src_b;
        dst_t             dst;
        cond_t            cond;
        logic [UPC_W-1:0] jump_addr;
        logic             done;
    } ctrl_t;

    // Entry points inside the microprogram.
    localparam logic [UPC_W-1:0] UPC_DIV_WAIT = 5'd8;
    localparam logic [UPC_W-1:0] UPC_CLEAR    = 5'd25;
    localparam logic [UPC_W-1:0] UPC_NONE     = 5'd0;

    // Magnitude of a signed value; the most negative value maps onto 2^(DATA_W-1).
    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    // Signed value from sign and wide magnitude, saturated to the data range.
    function automatic logic signed [DATA_W-1:0] qsat(input logic neg,
                                                      input logic [QUO_W-1:0] m);
        logic big;
        big = (m[QUO_W-1:DATA_W-1] != '0);
        if (!neg)
            return big ? VAL_MAX : m[DATA_W-1:0];
        else
            return big ? VAL_MIN : (~m[DATA_W-1:0] + 1'b1);
    endfunction

    // Saturating addition.
    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            return s[DATA_W] ? VAL_MIN : VAL_MAX;
        return s[DATA_W-1:0];
    endfunction

    // Saturating subtraction.
    function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            return s[DATA_W] ? VAL_MIN : VAL_MAX;
        return s[DATA_W-1:0];
    endfunction

    // Builds one control word.
    function automatic ctrl_t mk(input op_t op, input src_t sa, input src_t sb,
                                 input dst_t dst, input cond_t cond,
                                 input logic [UPC_W-1:0] jump_addr, input logic done);
        ctrl_t w;
        w.op        = op;
        w.src_a     = sa;
        w.src_b     = sb;
        w.dst       = dst;
        w.cond      = cond;
        w.jump_addr = jump_addr;
        w.done      = done;
        return w;
    endfunction

    // The microprogram: a control step from address 0, a clear from UPC_CLEAR.
    function automatic ctrl_t ucode(input logic [UPC_W-1:0] addr);
        ctrl_t w;
        case (addr)
            // Branch to the clear sequence when the item asks for it.
            5'd0:  w = mk(OP_NOP,   SRC_ZERO,   SRC_ZERO, DST_NONE, COND_MODE, UPC_CLEAR, 1'b0);
            5'd1:  w = mk(OP_SUB,   SRC_TARGET, SRC_MEAS, DST_ERR,  COND_NONE, UPC_NONE, 1'b0);
            5'd2:  w = mk(OP_SUB,   SRC_MEAS,   SRC_PREV, DST_DM,   COND_NONE, UPC_NONE, 1'b0);
            // Derivative numerator: tf*d - kd*dm.
            5'd3:  w = mk(OP_MUL,   SRC_TF,     SRC_FD,   DST_NONE, COND_NONE, UPC_NONE, 1'b0);
            5'd4:  w = mk(OP_MOV,   SRC_PROD,   SRC_ZERO, DST_A,    COND_NONE, UPC_NONE, 1'b0);
            5'd5:  w = mk(OP_MUL,   SRC_GD,     SRC_DM,   DST_NONE, COND_NONE, UPC_NONE, 1'b0);
            5'd6:  w = mk(OP_SUB,   SRC_A,      SRC_PROD, DST_A,    COND_NONE, UPC_NONE, 1'b0);
            // Divide by tf + dt and wait for the quotient.
            5'd7:  w = mk(OP_DIV,   SRC_A,      SRC_ZERO, DST_NONE, COND_NONE, UPC_NONE, 1'b0);
            5'd8:  w = mk(OP_NOP,   SRC_ZERO,   SRC_ZERO, DST_NONE, COND_DIV_BUSY,
                          UPC_DIV_WAIT, 1'b0);
            5'd9:  w = mk(OP_MOV,   SRC_DIVQ,   SRC_ZERO, DST_FD,   COND_NONE, UPC_NONE, 1'b0);
            // Drive and its clamped copy.
            5'd10: w = mk(OP_MUL,   SRC_GP,     SRC_ERR,  DST_NONE, COND_NONE, UPC_NONE, 1'b0);
            5'd11: w = mk(OP_ADD,   SRC_PROD,   SRC_FD,   DST_A,    COND_NONE, UPC_NONE, 1'b0);
            5'd12: w = mk(OP_ADD,   SRC_A,      SRC_INT,  DST_DRV,  COND_NONE, UPC_NONE, 1'b0);
            5'd13: w = mk(OP_CLAMP, SRC_DRV,    SRC_ZERO, DST_CLP,  COND_NONE, UPC_NONE, 1'b0);
            5'd14: w = mk(OP_SUB,   SRC_DRV,    SRC_CLP,  DST_A,    COND_NONE, UPC_NONE, 1'b0);
            // Integrator increment: (ki*dt)*err + (dt*kt)*(drive - clamped).
            5'd15: w = mk(OP_MUL,   SRC_GI,     SRC_DT,   DST_NONE, COND_NONE, UPC_NONE, 1'b0);
            5'd16: w = mk(OP_MOV,   SRC_PROD,   SRC_ZERO, DST_B,    COND_NONE, UPC_NONE, 1'b0);
            5'd17: w = mk(OP_MUL,   SRC_B,      SRC_ERR,  DST_NONE, COND_NONE, UPC_NONE, 1'b0);
            5'd18: w = mk(OP_MOV,   SRC_PROD,   SRC_ZERO, DST_B,    COND_NONE, UPC_NONE, 1'b0);
            5'd19: w = mk(OP_MUL,   SRC_DT,     SRC_GT,   DST_NONE, COND_NONE, UPC_NONE, 1'b0);
            5'd20: w = mk(OP_MOV,   SRC_PROD,   SRC_ZERO, DST_C,    COND_NONE, UPC_NONE, 1'b0);
            5'd21: w = mk(OP_MUL,   SRC_C,      SRC_A,    DST_NONE, COND_NONE, UPC_NONE, 1'b0);
            5'd22: w = mk(OP_ADD,   SRC_B,      SRC_PROD, DST_A,    COND_NONE, UPC_NONE, 1'b0);
            5'd23: w = mk(OP_ADD,   SRC_INT,    SRC_A,    DST_INT,  COND_NONE, UPC_NONE, 1'b0);
            5'd24: w = mk(OP_MOV,   SRC_MEAS,   SRC_ZERO, DST_PREV, COND_NONE, UPC_NONE, 1'b1);
            // Clear sequence.
            5'd25: w = mk(OP_CLEAR, SRC_ZERO,   SRC_ZERO, DST_NONE, COND_NONE, UPC_NONE, 1'b0);
            5'd26: w = mk(OP_NOP,   SRC_ZERO,   SRC_ZERO, DST_NONE, COND_NONE, UPC_NONE, 1'b1);
            default: w = mk(OP_NOP, SRC_ZERO,   SRC_ZERO, DST_NONE, COND_NONE, UPC_NONE, 1'b1);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/pfd_divider.sv
// Restoring divider forming (num << FRAC_W) / den one quotient bit per cycle.
module pfd_divider
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [pfd_pkg::DATA_W-1:0] num,
    input  logic        [pfd_pkg::DATA_W-1:0] den,
    output logic                             busy,
    output logic signed [pfd_pkg::DATA_W-1:0] quotient
);

    logic                          busy_reg, busy_next;
    logic [pfd_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                          neg_reg, neg_next;
    logic [pfd_pkg::QUO_W-1:0]     work_reg, work_next;
    logic [pfd_pkg::DATA_W-1:0]    rem_reg, rem_next;
    logic [pfd_pkg::DATA_W-1:0]    den_reg, den_next;
    logic [pfd_pkg::DATA_W:0]      trial;
    logic [pfd_pkg::DATA_W:0]      diff;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    // One restoring step per cycle; the dividend shifts out as quotient bits shift in.
    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        neg_next   = neg_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        trial      = {rem_reg, work_reg[pfd_pkg::QUO_W-1]};
        diff       = trial - {1'b0, den_reg};
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = pfd_pkg::CNT_W'(pfd_pkg::QUO_W);
            neg_next   = num[pfd_pkg::DATA_W-1];
            work_next  = {pfd_pkg::mag(num), {pfd_pkg::FRAC_W{1'b0}}};
            rem_next   = '0;
            den_next   = den;
        end
        else if (busy_reg)
        begin
            if (!diff[pfd_pkg::DATA_W])
            begin
                rem_next  = diff[pfd_pkg::DATA_W-1:0];
                work_next = {work_reg[pfd_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[pfd_pkg::DATA_W-1:0];
                work_next = {work_reg[pfd_pkg::QUO_W-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == pfd_pkg::CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    assign busy     = busy_reg;
    assign quotient = pfd_pkg::qsat(neg_reg, work_reg);

endmodule

>>> rtl/core/pfd_datapath.sv
// Datapath of the PID controller: operand selection, shared multiplier, adder, clamp and state.
module pfd_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pfd_pkg::ctrl_t                    ctrl,
    input  pfd_pkg::cfg_t                     cfg,
    input  logic signed [pfd_pkg::DATA_W-1:0] target_val,
    input  logic signed [pfd_pkg::DATA_W-1:0] meas_val,
    output logic                              div_busy,
    output logic signed [pfd_pkg::DATA_W-1:0] drive_val,
    output logic signed [pfd_pkg::DATA_W-1:0] clamped_val
);

    // Loop state, cleared at reset.
    logic signed [pfd_pkg::DATA_W-1:0] fd_reg, fd_next;
    logic signed [pfd_pkg::DATA_W-1:0] int_reg, int_next;
    logic signed [pfd_pkg::DATA_W-1:0] prev_reg, prev_next;

    // Scratch registers.
    logic signed [pfd_pkg::DATA_W-1:0] err_reg, err_next;
    logic signed [pfd_pkg::DATA_W-1:0] dm_reg, dm_next;
    logic signed [pfd_pkg::DATA_W-1:0] a_reg, a_next;
    logic signed [pfd_pkg::DATA_W-1:0] b_reg, b_next;
    logic signed [pfd_pkg::DATA_W-1:0] c_reg, c_next;
    logic signed [pfd_pkg::DATA_W-1:0] drv_reg, drv_next;
    logic signed [pfd_pkg::DATA_W-1:0] clp_reg, clp_next;

    // Multiplier output register.
    logic [pfd_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                       prod_neg_reg, prod_neg_next;

    logic signed [pfd_pkg::DATA_W-1:0] opa;
    logic signed [pfd_pkg::DATA_W-1:0] opb;
    logic signed [pfd_pkg::DATA_W-1:0] prod_val;
    logic signed [pfd_pkg::DATA_W-1:0] quo_val;
    logic signed [pfd_pkg::DATA_W-1:0] res;
    logic        [pfd_pkg::DATA_W-1:0] den_sum;
    logic        [pfd_pkg::DATA_W-1:0] den;
    logic                              div_start;

    // Saturated, rescaled view of the last product.
    assign prod_val = pfd_pkg::qsat(prod_neg_reg,
                                    prod_reg[pfd_pkg::PROD_W-1:pfd_pkg::FRAC_W]);

    // Denominator tf + dt, with zero taken as one least significant bit.
    assign den_sum = {1'b0, cfg.filter_time} + {1'b0, cfg.sample_period};
    assign den     = (den_sum == '0) ? pfd_pkg::DATA_W'(1) : den_sum;

    assign div_start = (ctrl.op == pfd_pkg::OP_DIV);

    pfd_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (opa),
        .den      (den),
        .busy     (div_busy),
        .quotient (quo_val)
    );

    // Operand selection.
    function automatic logic signed [pfd_pkg::DATA_W-1:0] pick(input pfd_pkg::src_t s,
        input logic signed [pfd_pkg::DATA_W-1:0] t, input logic signed [pfd_pkg::DATA_W-1:0] m,
        input logic signed [pfd_pkg::DATA_W-1:0] p, input logic signed [pfd_pkg::DATA_W-1:0] f,
        input logic signed [pfd_pkg::DATA_W-1:0] i, input logic signed [pfd_pkg::DATA_W-1:0] e,
        input logic signed [pfd_pkg::DATA_W-1:0] d, input logic signed [pfd_pkg::DATA_W-1:0] ra,
        input logic signed [pfd_pkg::DATA_W-1:0] rb, input logic signed [pfd_pkg::DATA_W-1:0] rc,
        input logic signed [pfd_pkg::DATA_W-1:0] dv, input logic signed [pfd_pkg::DATA_W-1:0] cl,
        input logic signed [pfd_pkg::DATA_W-1:0] pr, input logic signed [pfd_pkg::DATA_W-1:0] q,
        input pfd_pkg::cfg_t c);
        case (s)
            pfd_pkg::SRC_TARGET: return t;
            pfd_pkg::SRC_MEAS:   return m;
            pfd_pkg::SRC_PREV:   return p;
            pfd_pkg::SRC_FD:     return f;
            pfd_pkg::SRC_INT:    return i;
            pfd_pkg::SRC_ERR:    return e;
            pfd_pkg::SRC_DM:     return d;
            pfd_pkg::SRC_A:      return ra;
            pfd_pkg::SRC_B:      return rb;
            pfd_pkg::SRC_C:      return rc;
            pfd_pkg::SRC_DRV:    return dv;
            pfd_pkg::SRC_CLP:    return cl;
            pfd_pkg::SRC_PROD:   return pr;
            pfd_pkg::SRC_DIVQ:   return q;
            pfd_pkg::SRC_GP:     return c.gain_p;
            pfd_pkg::SRC_GI:     return c.gain_i;
            pfd_pkg::SRC_GD:     return c.gain_d;
            pfd_pkg::SRC_GT:     return c.gain_tracking;
            pfd_pkg::SRC_TF:     return {1'b0, c.filter_time};
            pfd_pkg::SRC_DT:     return {1'b0, c.sample_period};
            default:             return '0;
        endcase
    endfunction

    assign opa = pick(ctrl.src_a, target_val, meas_val, prev_reg, fd_reg, int_reg, err_reg,
                      dm_reg, a_reg, b_reg, c_reg, drv_reg, clp_reg, prod_val, quo_val, cfg);
    assign opb = pick(ctrl.src_b, target_val, meas_val, prev_reg, fd_reg, int_reg, err_reg,
                      dm_reg, a_reg, b_reg, c_reg, drv_reg, clp_reg, prod_val, quo_val, cfg);

    // Combinational result of the adder or the clamp; other operations pass operand a through.
    always_comb
    begin
        case (ctrl.op)
            pfd_pkg::OP_ADD: res = pfd_pkg::sat_add(opa, opb);
            pfd_pkg::OP_SUB: res = pfd_pkg::sat_sub(opa, opb);
            pfd_pkg::OP_CLAMP:
            begin
                if (opa < cfg.output_low)
                    res = cfg.output_low;
                else if (opa > cfg.output_high)
                    res = cfg.output_high;
                else
                    res = opa;
            end
            default: res = opa;
        endcase
    end

    // Register write-back, multiplier load and clear.
    always_comb
    begin
        fd_next       = fd_reg;
        int_next      = int_reg;
        prev_next     = prev_reg;
        err_next      = err_reg;
        dm_next       = dm_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        drv_next      = drv_reg;
        clp_next      = clp_reg;
        prod_next     = prod_reg;
        prod_neg_next = prod_neg_reg;
        case (ctrl.dst)
            pfd_pkg::DST_ERR:  err_next  = res;
            pfd_pkg::DST_DM:   dm_next   = res;
            pfd_pkg::DST_A:    a_next    = res;
            pfd_pkg::DST_B:    b_next    = res;
            pfd_pkg::DST_C:    c_next    = res;
            pfd_pkg::DST_DRV:  drv_next  = res;
            pfd_pkg::DST_CLP:  clp_next  = res;
            pfd_pkg::DST_FD:   fd_next   = res;
            pfd_pkg::DST_INT:  int_next  = res;
            pfd_pkg::DST_PREV: prev_next = res;
            default:           ;
        endcase
        if (ctrl.op == pfd_pkg::OP_MUL)
        begin
            prod_next     = pfd_pkg::mag(opa) * pfd_pkg::mag(opb);
            prod_neg_next = opa[pfd_pkg::DATA_W-1] ^ opb[pfd_pkg::DATA_W-1];
        end
        if (ctrl.op == pfd_pkg::OP_CLEAR)
        begin
            fd_next  = '0;
            int_next = '0;
            drv_next = '0;
            clp_next = '0;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fd_reg   <= '0;
            int_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            fd_reg   <= fd_next;
            int_reg  <= int_next;
            prev_reg <= prev_next;
        end
    end

    // Scratch and product registers.
    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        dm_reg       <= dm_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        drv_reg      <= drv_next;
        clp_reg      <= clp_next;
        prod_reg     <= prod_next;
        prod_neg_reg <= prod_neg_next;
    end

    assign drive_val   = drv_reg;
    assign clamped_val = clp_reg;

endmodule

>>> rtl/core/pfd_sequencer.sv
// Microprogram sequencer: step counter, control-store fetch and conditional jumps.
module pfd_sequencer
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           mode,
    input  logic           div_busy,
    input  logic           out_free,
    output pfd_pkg::ctrl_t ctrl,
    output logic           running,
    output logic           done
);

    logic [pfd_pkg::UPC_W-1:0] step_reg, step_next;
    logic                      running_reg, running_next;
    logic                      mode_reg, mode_next;
    pfd_pkg::ctrl_t            word;
    logic                      cond_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            running_reg <= 1'b0;
            mode_reg    <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            running_reg <= running_next;
            mode_reg    <= mode_next;
        end
    end

    assign word = pfd_pkg::ucode(step_reg);

    // Jump condition of the current step.
    always_comb
    begin
        case (word.cond)
            pfd_pkg::COND_MODE:     cond_hit = mode_reg;
            pfd_pkg::COND_DIV_BUSY: cond_hit = div_busy;
            default:                cond_hit = 1'b0;
        endcase
    end

    // Next step; the last step holds until the output register is free.
    always_comb
    begin
        step_next    = step_reg;
        running_next = running_reg;
        mode_next    = mode_reg;
        done         = 1'b0;
        if (start)
        begin
            step_next    = '0;
            running_next = 1'b1;
            mode_next    = mode;
        end
        else if (running_reg)
        begin
            if (word.done)
            begin
                if (out_free)
                begin
                    running_next = 1'b0;
                    done         = 1'b1;
                end
            end
            else if (cond_hit)
                step_next = word.jump_addr;
            else
                step_next = step_reg + 1'b1;
        end
    end

    // Nothing is issued to the datapath while idle.
    always_comb
    begin
        if (running_reg)
            ctrl = word;
        else
            ctrl = pfd_pkg::mk(pfd_pkg::OP_NOP, pfd_pkg::SRC_ZERO, pfd_pkg::SRC_ZERO,
                               pfd_pkg::DST_NONE, pfd_pkg::COND_NONE, pfd_pkg::UPC_NONE, 1'b0);
    end

    assign running = running_reg;

endmodule

>>> rtl/core/pid_filtered_derivative_antiwindup_top.sv
// Top level of the PID controller with filtered derivative and back-calculation anti-windup.
//
// Input channel (in_valid, in_stall, mode, target, measured): one beat is one control
// step, or a clear of the integrator and derivative when mode is set. in_stall is high
// while an item is being worked on, so one item is in flight at a time.
// Output channel (out_valid, out_stall, drive, drive_clamped): one beat per input beat,
// held in an output register; the next item is taken while a result waits there.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high and registers are to be written only while the block is idle.
// A control step runs the microcode from acceptance to the result being loaded, holding on
// the step that waits for the bit-serial divider; a clear runs only the clear sequence.
// The next item can be taken in the cycle after the result is loaded.
// The divider loop sets the rate, one quotient bit per cycle.
// If out_stall holds a previous result, the microprogram waits on its last step.
// Reset clears the loop state, returns the registers to their defaults and empties
// the output register.
module pid_filtered_derivative_antiwindup_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 mode,
    input  logic signed [pfd_pkg::DATA_W-1:0]    target,
    input  logic signed [pfd_pkg::DATA_W-1:0]    measured,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pfd_pkg::DATA_W-1:0]    drive,
    output logic signed [pfd_pkg::DATA_W-1:0]    drive_clamped,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [pfd_pkg::DATA_W-1:0]    cfg_data
);

    pfd_pkg::cfg_t  cfg_reg, cfg_next;
    logic signed [pfd_pkg::DATA_W-1:0] target_reg, target_next;
    logic signed [pfd_pkg::DATA_W-1:0] meas_reg, meas_next;
    logic                              out_valid_reg, out_valid_next;
    logic signed [pfd_pkg::DATA_W-1:0] drive_reg, drive_next;
    logic signed [pfd_pkg::DATA_W-1:0] clamped_reg, clamped_next;

    pfd_pkg::ctrl_t                    ctrl;
    logic                              running;
    logic                              done;
    logic                              div_busy;
    logic                              in_accept;
    logic                              out_free;
    logic signed [pfd_pkg::DATA_W-1:0] drive_val;
    logic signed [pfd_pkg::DATA_W-1:0] clamped_val;

    assign cfg_ready = 1'b1;
    assign in_stall  = running;
    assign in_accept = in_valid && !running;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                pfd_pkg::CFG_GAIN_P:        cfg_next.gain_p        = cfg_data;
                pfd_pkg::CFG_GAIN_I:        cfg_next.gain_i        = cfg_data;
                pfd_pkg::CFG_GAIN_D:        cfg_next.gain_d        = cfg_data;
                pfd_pkg::CFG_GAIN_TRACKING: cfg_next.gain_tracking = cfg_data;
                pfd_pkg::CFG_FILTER_TIME:
                    cfg_next.filter_time = cfg_data[pfd_pkg::PARAM_W-1:0];
                pfd_pkg::CFG_SAMPLE_PERIOD:
                    cfg_next.sample_period = cfg_data[pfd_pkg::PARAM_W-1:0];
                pfd_pkg::CFG_OUTPUT_LOW:    cfg_next.output_low    = cfg_data;
                pfd_pkg::CFG_OUTPUT_HIGH:   cfg_next.output_high   = cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p        <= 32'sd65536;
            cfg_reg.gain_i        <= '0;
            cfg_reg.gain_d        <= '0;
            cfg_reg.gain_tracking <= '0;
            cfg_reg.filter_time   <= 31'd65536;
            cfg_reg.sample_period <= 31'd655;
            cfg_reg.output_low    <= '0;
            cfg_reg.output_high   <= 32'sd65536;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input capture and output register.
    always_comb
    begin
        target_next    = target_reg;
        meas_next      = meas_reg;
        out_valid_next = out_valid_reg;
        drive_next     = drive_reg;
        clamped_next   = clamped_reg;
        if (in_accept)
        begin
            target_next = target;
            meas_next   = measured;
        end
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (done)
        begin
            out_valid_next = 1'b1;
            drive_next     = drive_val;
            clamped_next   = clamped_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        target_reg  <= target_next;
        meas_reg    <= meas_next;
        drive_reg   <= drive_next;
        clamped_reg <= clamped_next;
    end

    pfd_sequencer u_sequencer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .mode     (mode),
        .div_busy (div_busy),
        .out_free (out_free),
        .ctrl     (ctrl),
        .running  (running),
        .done     (done)
    );

    pfd_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cfg         (cfg_reg),
        .target_val  (target_reg),
        .meas_val    (meas_reg),
        .div_busy    (div_busy),
        .drive_val   (drive_val),
        .clamped_val (clamped_val)
    );

    assign out_valid     = out_valid_reg;
    assign drive         = drive_reg;
    assign drive_clamped = clamped_reg;

endmodule

>>> tb/pid_filtered_derivative_antiwindup_top_tb.sv
// Self-checking testbench for the PID controller with filtered derivative and anti-windup.
`timescale 1ns / 100ps

module pid_filtered_derivative_antiwindup_top_tb;

    import pfd_pkg::*;

    typedef logic signed [DATA_W-1:0] q_t;

    // Raw and clamped drive of one result beat.
    typedef struct packed {
        q_t raw;
        q_t clamped;
    } drive_pair_t;

    typedef enum logic {ROW_STEP, ROW_WRITE} row_kind_e;

    // One row of the directed plan: either an input beat or a register write.
    typedef struct packed {
        row_kind_e                kind;
        logic                     mode;
        q_t                       tgt;
        q_t                       meas;
        logic                     known;
        q_t                       raw;
        q_t                       clamped;
        logic [CFG_IDX_W-1:0]     idx;
        logic [DATA_W-1:0]        data;
    } plan_row_t;

    localparam bit     MODE_STEP   = 1'b0;
    localparam bit     MODE_CLEAR  = 1'b1;
    localparam int     Q_ONE       = 1 << FRAC_W;
    localparam longint Q_MAX_L     = longint'(VAL_MAX);
    localparam longint Q_MIN_L     = longint'(VAL_MIN);
    localparam int     PLAN_N      = 39;
    localparam int     PHASES      = 14;
    localparam int     PHASE_ITEMS = 100;

    // Directed plan. Expected drives are typed in only where they are obvious.
    localparam plan_row_t PLAN [0:PLAN_N-1] = '{
        // Reset settings: drive is the plain error, clamped to 0 .. 1.0.
        '{ROW_STEP,  MODE_STEP,  5 * Q_ONE, 0,       1'b1, 5 * Q_ONE, Q_ONE, '0, '0},
        '{ROW_STEP,  MODE_STEP,  0,         0,       1'b1, 0,         0,     '0, '0},
        '{ROW_STEP,  MODE_STEP,  Q_ONE / 2, 0,       1'b1, Q_ONE / 2, Q_ONE / 2, '0, '0},
        '{ROW_STEP,  MODE_STEP,  0,         Q_ONE,   1'b1, -Q_ONE,    0,     '0, '0},
        '{ROW_STEP,  MODE_STEP,  VAL_MAX,   VAL_MIN, 1'b1, VAL_MAX,   Q_ONE, '0, '0},
        '{ROW_STEP,  MODE_STEP,  VAL_MIN,   VAL_MAX, 1'b1, VAL_MIN,   0,     '0, '0},
        '{ROW_STEP,  MODE_CLEAR, 32'h5A5A_A5A5, VAL_MIN, 1'b1, 0,     0,     '0, '0},
        // All three terms active.
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_GAIN_I,        2 * Q_ONE},
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_GAIN_D,        -3 * Q_ONE / 2},
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_GAIN_TRACKING, Q_ONE / 2},
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_FILTER_TIME,   6554},
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_SAMPLE_PERIOD, Q_ONE / 4},
        '{ROW_STEP,  MODE_STEP,  10 * Q_ONE,  2 * Q_ONE, 1'b0, 0, 0, '0, '0},
        '{ROW_STEP,  MODE_STEP,  10 * Q_ONE,  3 * Q_ONE, 1'b0, 0, 0, '0, '0},
        '{ROW_STEP,  MODE_STEP,  10 * Q_ONE,  5 * Q_ONE, 1'b0, 0, 0, '0, '0},
        '{ROW_STEP,  MODE_STEP,  -10 * Q_ONE, 6 * Q_ONE, 1'b0, 0, 0, '0, '0},
        '{ROW_STEP,  MODE_CLEAR, -1,          0,         1'b1, 0, 0, '0, '0},
        '{ROW_STEP,  MODE_STEP,  Q_ONE,       0,         1'b0, 0, 0, '0, '0},
        // Crossed limits.
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_OUTPUT_LOW,    Q_ONE},
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_OUTPUT_HIGH,   -Q_ONE},
        '{ROW_STEP,  MODE_STEP,  0,          0, 1'b0, 0, 0, '0, '0},
        '{ROW_STEP,  MODE_STEP,  3 * Q_ONE,  0, 1'b0, 0, 0, '0, '0},
        '{ROW_STEP,  MODE_STEP,  -3 * Q_ONE, 0, 1'b0, 0, 0, '0, '0},
        // Extreme gains and time constants.
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_GAIN_P,        VAL_MAX},
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_GAIN_I,        VAL_MIN},
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_GAIN_D,        VAL_MAX},
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_GAIN_TRACKING, VAL_MIN},
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_FILTER_TIME,   1},
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_SAMPLE_PERIOD, 32'h7FFF_FFFF},
        '{ROW_STEP,  MODE_STEP,  VAL_MAX, VAL_MIN, 1'b0, 0, 0, '0, '0},
        '{ROW_STEP,  MODE_STEP,  VAL_MIN, VAL_MAX, 1'b0, 0, 0, '0, '0},
        '{ROW_STEP,  MODE_STEP,  0,       0,       1'b0, 0, 0, '0, '0},
        // Filter time and sample period both zero: the divisor falls back to one LSB.
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_GAIN_P,        Q_ONE},
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_GAIN_D,        Q_ONE},
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_FILTER_TIME,   0},
        '{ROW_WRITE, MODE_STEP, 0, 0, 1'b0, 0, 0, CFG_SAMPLE_PERIOD, 0},
        '{ROW_STEP,  MODE_STEP,  0,     2 * Q_ONE,  1'b0, 0, 0, '0, '0},
        '{ROW_STEP,  MODE_STEP,  0,     -2 * Q_ONE, 1'b0, 0, 0, '0, '0},
        '{ROW_STEP,  MODE_STEP,  Q_ONE, Q_ONE,      1'b0, 0, 0, '0, '0}
    };

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic                 mode          = 1'b0;
    q_t                   target        = '0;
    q_t                   measured      = '0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    q_t                   drive;
    q_t                   drive_clamped;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [DATA_W-1:0]    cfg_data      = '0;

    // Predictor state: register copy and loop state.
    cfg_t        coeffs;
    q_t          integ_acc;
    q_t          deriv_filt;
    q_t          last_meas;

    drive_pair_t pending_drives [$];
    int unsigned fault_count = 0;
    int          next_gap    = 0;
    int          stall_left  = 0;
    bit          in_calm     = 1'b0;
    bit          out_calm    = 1'b0;

    always #1 clk = ~clk;

    pid_filtered_derivative_antiwindup_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .target        (target),
        .measured      (measured),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .drive         (drive),
        .drive_clamped (drive_clamped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Saturates a wide value to the data range.
    function automatic q_t fx_sat(longint v);
        if (v > Q_MAX_L)
            return VAL_MAX;
        if (v < Q_MIN_L)
            return VAL_MIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic q_t fx_add(q_t a, q_t b);
        return fx_sat(longint'(a) + longint'(b));
    endfunction

    function automatic q_t fx_sub(q_t a, q_t b);
        return fx_sat(longint'(a) - longint'(b));
    endfunction

    function automatic longint unsigned q_mag(q_t v);
        longint s;
        s = v;
        return (s < 0) ? -s : s;
    endfunction

    // Fixed-point product: exact magnitude, shifted down, so truncation is toward zero.
    function automatic q_t fx_mul(q_t a, q_t b);
        longint unsigned prod;
        prod = (q_mag(a) * q_mag(b)) >> FRAC_W;
        return fx_sat(((a < 0) != (b < 0)) ? -longint'(prod) : longint'(prod));
    endfunction

    // Fixed-point quotient of a signed numerator by a positive divisor.
    function automatic q_t fx_div(q_t num, longint unsigned den);
        longint unsigned quo;
        quo = (q_mag(num) << FRAC_W) / den;
        return fx_sat((num < 0) ? -longint'(quo) : longint'(quo));
    endfunction

    // One controller step: derivative filter, drive, clamp and integrator update.
    function automatic void control_step(bit clr, q_t tgt, q_t meas, output drive_pair_t res);
        q_t              err;
        q_t              dm;
        q_t              num;
        q_t              tf;
        q_t              dt;
        q_t              lo_lim;
        q_t              hi_lim;
        q_t              inc;
        longint unsigned den;
        if (clr)
        begin
            integ_acc   = '0;
            deriv_filt  = '0;
            res.raw     = '0;
            res.clamped = '0;
            return;
        end
        tf     = {1'b0, coeffs.filter_time};
        dt     = {1'b0, coeffs.sample_period};
        lo_lim = coeffs.output_low;
        hi_lim = coeffs.output_high;

        err = fx_sub(tgt, meas);
        dm  = fx_sub(meas, last_meas);
        num = fx_sub(fx_mul(tf, deriv_filt), fx_mul(coeffs.gain_d, dm));
        den = coeffs.filter_time + coeffs.sample_period;
        if (den == 0)
            den = 1;
        deriv_filt = fx_div(num, den);

        res.raw = fx_add(fx_add(fx_mul(coeffs.gain_p, err), deriv_filt), integ_acc);
        // With crossed limits the lower limit is tested first.
        if (res.raw < lo_lim)
            res.clamped = lo_lim;
        else if (res.raw > hi_lim)
            res.clamped = hi_lim;
        else
            res.clamped = res.raw;

        // Back-calculation: the clamped-off part of the drive bleeds the integrator.
        inc = fx_add(fx_mul(fx_mul(coeffs.gain_i, dt), err),
                     fx_mul(fx_mul(dt, coeffs.gain_tracking), fx_sub(res.raw, res.clamped)));
        integ_acc = fx_add(integ_acc, inc);
        last_meas = meas;
    endfunction

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [DATA_W-1:0] draw_gain();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return $urandom();
            default: return $urandom_range(0, 8 * Q_ONE) - 4 * Q_ONE;
        endcase
    endfunction

    // Time constants are 31 bits; the top data bit is random and must be ignored.
    function automatic logic [DATA_W-1:0] draw_period();
        logic [PARAM_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 1;
            1:       v = '1;
            2:       v = $urandom_range(1, 32'h7FFF_FFFF);
            default: v = $urandom_range(1, 2 * Q_ONE);
        endcase
        return {1'($urandom_range(0, 1)), v};
    endfunction

    // Drives one input beat, records its expected result once accepted.
    // With more set and no gap drawn, valid stays high into the next beat.
    task automatic send_item(bit clr, q_t tgt, q_t meas, bit more,
                             bit known = 1'b0, q_t raw_k = '0, q_t clp_k = '0);
        drive_pair_t want;
        repeat (next_gap) @(posedge clk);
        in_valid <= 1'b1;
        mode     <= clr;
        target   <= tgt;
        measured <= meas;
        do
            @(posedge clk);
        while (in_stall);
        control_step(clr, tgt, meas, want);
        if (known)
        begin
            want.raw     = raw_k;
            want.clamped = clp_k;
        end
        pending_drives.push_back(want);
        next_gap = draw_gap(in_calm);
        if (!more || next_gap != 0)
            in_valid <= 1'b0;
    endtask

    // Writes one register; valid stays high across a run of writes until the last.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data, bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_GAIN_P:        coeffs.gain_p        = data;
            CFG_GAIN_I:        coeffs.gain_i        = data;
            CFG_GAIN_D:        coeffs.gain_d        = data;
            CFG_GAIN_TRACKING: coeffs.gain_tracking = data;
            CFG_FILTER_TIME:   coeffs.filter_time   = data[PARAM_W-1:0];
            CFG_SAMPLE_PERIOD: coeffs.sample_period = data[PARAM_W-1:0];
            CFG_OUTPUT_LOW:    coeffs.output_low    = data;
            default:           coeffs.output_high   = data;
        endcase
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // Waits until every expected result has arrived and the block has gone quiet.
    task automatic settle();
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Receiver: each result is held back for a drawn number of cycles while it waits.
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_left = 0;
        else if (out_valid && !out_stall)
            stall_left = draw_gap(out_calm);
        else if (out_valid && stall_left != 0)
            stall_left--;
        out_stall <= (stall_left != 0);
    end

    // Compares each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        drive_pair_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_drives.size() == 0)
            begin
                $error("result beat with nothing expected: drive %0d, drive_clamped %0d",
                       drive, drive_clamped);
                fault_count++;
            end
            else
            begin
                want = pending_drives.pop_front();
                if (drive !== want.raw)
                begin
                    $error("drive: expected %0d, got %0d", want.raw, drive);
                    fault_count++;
                end
                if (drive_clamped !== want.clamped)
                begin
                    $error("drive_clamped: expected %0d, got %0d", want.clamped, drive_clamped);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [DATA_W-1:0] gp;
        logic [DATA_W-1:0] gi;
        logic [DATA_W-1:0] gd;
        logic [DATA_W-1:0] gt;
        logic [DATA_W-1:0] tf;
        logic [DATA_W-1:0] dt;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        int                aim;
        int                plant;
        int                nudge;
        int                pick;
        bit                more;

        // Register defaults and cleared loop state, as after reset.
        coeffs.gain_p        = Q_ONE;
        coeffs.gain_i        = '0;
        coeffs.gain_d        = '0;
        coeffs.gain_tracking = '0;
        coeffs.filter_time   = Q_ONE;
        coeffs.sample_period = 655;
        coeffs.output_low    = '0;
        coeffs.output_high   = Q_ONE;
        integ_acc            = '0;
        deriv_filt           = '0;
        last_meas            = '0;
        plant                = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan; register writes wait until the block is idle.
        in_calm  = ($urandom_range(0, 1) == 0);
        out_calm = ($urandom_range(0, 1) == 0);
        for (int i = 0; i < PLAN_N; i++)
        begin
            if (PLAN[i].kind == ROW_WRITE)
            begin
                if (i == 0 || PLAN[i-1].kind != ROW_WRITE)
                    settle();
                write_reg(PLAN[i].idx, PLAN[i].data,
                          i == PLAN_N - 1 || PLAN[i+1].kind != ROW_WRITE);
            end
            else
            begin
                more = (i < PLAN_N - 1) && (PLAN[i+1].kind == ROW_STEP);
                send_item(PLAN[i].mode, PLAN[i].tgt, PLAN[i].meas, more,
                          PLAN[i].known, PLAN[i].raw, PLAN[i].clamped);
            end
        end

        // Random phases, each under a fresh register setting.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    gp = VAL_MAX;
                    gi = VAL_MAX;
                    gd = VAL_MAX;
                    gt = VAL_MAX;
                    tf = 32'h7FFF_FFFF;
                    dt = 32'h7FFF_FFFF;
                    lo = VAL_MIN;
                    hi = VAL_MAX;
                end
                1:
                begin
                    gp = VAL_MIN;
                    gi = VAL_MIN;
                    gd = VAL_MIN;
                    gt = VAL_MIN;
                    tf = 1;
                    dt = 1;
                    lo = VAL_MAX;
                    hi = VAL_MIN;
                end
                default:
                begin
                    gp = draw_gain();
                    gi = draw_gain();
                    gd = draw_gain();
                    gt = draw_gain();
                    tf = draw_period();
                    dt = draw_period();
                    case ($urandom_range(0, 7))
                        0:
                        begin
                            lo = VAL_MIN;
                            hi = VAL_MAX;
                        end
                        1:
                        begin
                            lo = $urandom_range(0, 5 * Q_ONE);
                            hi = lo - $urandom_range(1, 5 * Q_ONE);
                        end
                        default:
                        begin
                            lo = $urandom_range(0, 10 * Q_ONE) - 10 * Q_ONE;
                            hi = lo + $urandom_range(0, 20 * Q_ONE);
                        end
                    endcase
                end
            endcase
            write_reg(CFG_GAIN_P,        gp, 1'b0);
            write_reg(CFG_GAIN_I,        gi, 1'b0);
            write_reg(CFG_GAIN_D,        gd, 1'b0);
            write_reg(CFG_GAIN_TRACKING, gt, 1'b0);
            write_reg(CFG_FILTER_TIME,   tf, 1'b0);
            write_reg(CFG_SAMPLE_PERIOD, dt, 1'b0);
            write_reg(CFG_OUTPUT_LOW,    lo, 1'b0);
            write_reg(CFG_OUTPUT_HIGH,   hi, 1'b1);

            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            aim      = $urandom_range(0, 100 * Q_ONE) - 50 * Q_ONE;

            // Mostly a plant that drifts towards the setpoint with noise,
            // plus occasional clears and full-range values.
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                more = (n != PHASE_ITEMS - 1);
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_item(MODE_CLEAR, $urandom(), $urandom(), more);
                else if (pick < 12)
                    send_item(MODE_STEP, $urandom(), $urandom(), more);
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                        aim = $urandom_range(0, 200 * Q_ONE) - 100 * Q_ONE;
                    nudge = $urandom_range(0, Q_ONE) - Q_ONE / 2;
                    plant = plant + (aim - plant) / 16 + nudge;
                    send_item(MODE_STEP, aim, plant, more);
                end
            end
        end

        // Drain, then allow a full step's latency for anything unexpected.
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (fault_count == 0)
            $display("pid_filtered_derivative_antiwindup_top_tb: PASS");
        else
            $display("pid_filtered_derivative_antiwindup_top_tb: FAIL");
        $finish;
    end

    // Timeout guard, well beyond the slowest correct run.
    initial
    begin : watchdog
        #2_000_000;
        $display("pid_filtered_derivative_antiwindup_top_tb: FAIL");
        $finish;
    end

endmodule
